// File: rtl/gha_pkg.sv
`default_nettype none

package gha_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_BITS  = 8;
    localparam int GEN_BITS   = 16;
    localparam int IDX_BITS   = 16;
    localparam int COUNT_BITS = 9;
    localparam int STK_BITS   = SLOT_BITS + GEN_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(SLOTS);
    localparam logic [GEN_BITS-1:0]   GEN_FIRST  = GEN_BITS'(1);

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_STALE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [IDX_BITS-1:0] slot_index;
        logic [GEN_BITS-1:0] slot_generation;
    } t_req;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [GEN_BITS-1:0]  gen;
    } t_stk_entry;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        logic [GEN_BITS-1:0]  data;
    } t_gen_wr;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        t_stk_entry           data;
    } t_stk_wr;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  handle_index;
        logic [GEN_BITS-1:0]   handle_generation;
        logic                  is_live;
        logic [COUNT_BITS-1:0] live_count;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/gha_ram.sv
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read in the same cycle as a write to the same entry returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/gha_engine.sv
`default_nettype none

module gha_engine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_adv,
    input  wire logic                                i_take,
    input  wire gha_pkg::t_req                       i_req,
    input  wire logic [gha_pkg::GEN_BITS-1:0]        i_gen_rd,
    input  wire gha_pkg::t_stk_entry                 i_stk_rd,
    output gha_pkg::t_gen_wr                         o_gen_wr,
    output gha_pkg::t_stk_wr                         o_stk_wr,
    output logic [gha_pkg::COUNT_BITS-1:0]           o_next_depth,
    output logic                                     o_valid,
    output gha_pkg::t_result                         o_result
);

    logic [gha_pkg::SLOTS-1:0]      r_alive;
    logic [gha_pkg::SLOTS-1:0]      n_alive;
    logic [gha_pkg::COUNT_BITS-1:0] r_depth;
    logic [gha_pkg::COUNT_BITS-1:0] n_depth;
    logic [gha_pkg::COUNT_BITS-1:0] r_used;
    logic [gha_pkg::COUNT_BITS-1:0] n_used;
    logic                           r_valid;
    gha_pkg::t_result               r_result;
    gha_pkg::t_result               n_result;

    logic [gha_pkg::SLOT_BITS-1:0]  lo;
    logic                           in_range;
    logic                           live;
    logic                           is_alloc;
    logic                           is_free;
    logic                           pop;
    logic                           claim;
    logic                           free_ok;
    logic [gha_pkg::SLOT_BITS-1:0]  alloc_slot;
    logic [gha_pkg::GEN_BITS-1:0]   alloc_gen;

    always_comb begin
        lo       = i_req.slot_index[gha_pkg::SLOT_BITS-1:0];
        in_range = (i_req.slot_index[gha_pkg::IDX_BITS-1:gha_pkg::SLOT_BITS] == '0);
        live     = in_range && ({1'b0, lo} < r_used) && r_alive[lo]
                   && (i_gen_rd == i_req.slot_generation);
        is_alloc = (i_req.kind == gha_pkg::KIND_ALLOC);
        is_free  = (i_req.kind == gha_pkg::KIND_FREE);
        pop      = is_alloc && (r_depth != '0);
        claim    = is_alloc && (r_depth == '0) && (r_used != gha_pkg::COUNT_FULL);
        free_ok  = is_free && live && (r_depth != gha_pkg::COUNT_FULL);

        alloc_slot = pop ? i_stk_rd.slot : r_used[gha_pkg::SLOT_BITS-1:0];
        alloc_gen  = pop ? (i_stk_rd.gen + gha_pkg::GEN_BITS'(1)) : gha_pkg::GEN_FIRST;

        n_depth = r_depth;
        n_used  = r_used;
        n_alive = r_alive;
        if (i_adv) begin
            if (pop) begin
                n_depth = r_depth - gha_pkg::COUNT_BITS'(1);
            end
            if (free_ok) begin
                n_depth = r_depth + gha_pkg::COUNT_BITS'(1);
                n_alive[lo] = 1'b0;
            end
            if (claim) begin
                n_used = r_used + gha_pkg::COUNT_BITS'(1);
            end
            if (pop || claim) begin
                n_alive[alloc_slot] = 1'b1;
            end
        end

        o_gen_wr.en   = i_adv && (pop || claim);
        o_gen_wr.addr = alloc_slot;
        o_gen_wr.data = alloc_gen;

        o_stk_wr.en        = i_adv && free_ok;
        o_stk_wr.addr      = r_depth[gha_pkg::SLOT_BITS-1:0];
        o_stk_wr.data.slot = lo;
        o_stk_wr.data.gen  = i_req.slot_generation;

        n_result.status = gha_pkg::STATUS_OK;
        if (is_alloc) begin
            if (!pop && !claim) begin
                n_result.status = gha_pkg::STATUS_FULL;
            end
        end else if (is_free) begin
            if (!free_ok) begin
                n_result.status = gha_pkg::STATUS_STALE;
            end
        end else if (!live) begin
            n_result.status = gha_pkg::STATUS_STALE;
        end
        n_result.handle_index      = (pop || claim) ? alloc_slot : lo;
        n_result.handle_generation = (pop || claim) ? alloc_gen : '0;
        n_result.is_live           = is_free ? free_ok : (!is_alloc && live);
        n_result.live_count        = n_used - n_depth;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_depth <= '0;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_alive <= n_alive;
            r_depth <= n_depth;
            r_used  <= n_used;
            if (i_adv) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_result <= n_result;
        end
    end

    assign o_next_depth = n_depth;
    assign o_valid      = r_valid;
    assign o_result     = r_result;

    a_depth_within_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_used)
        else $error("free stack deeper than the high-water mark");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= gha_pkg::COUNT_FULL)
        else $error("high-water mark beyond the pool size");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_result.live_count == (r_used - r_depth)))
        else $error("held live count disagrees with the counters");

    a_alloc_marks_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (pop || claim)) |=> r_alive[$past(alloc_slot)])
        else $error("allocated slot not marked alive");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && is_alloc && !pop && !claim)
            |-> (r_used == gha_pkg::COUNT_FULL) && (r_depth == '0))
        else $error("pool full reported with slots available");

endmodule

`default_nettype wire

// File: rtl/generational_handle_allocator_core.sv
// Channel  Direction  Handshake           Fields
// request  in         i_valid / o_stall   i_kind, i_slot_index, i_slot_generation
// result   out        o_valid / i_stall   o_status, o_handle_index, o_handle_generation,
//                                         o_is_live, o_live_count
//
// One word per cycle is accepted while o_stall is low; the result is registered.
// The generation and free stack memories are read at acceptance and bypassed against
// the write of the word ahead, so every request is a single read-modify-write pass.
// Reset clears the alive marks and both counters; no clearing pass runs.
// A stalled result holds the word behind it, and o_stall rises only while both are held.
`default_nettype none

module generational_handle_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_slot_index,
    input  wire logic [15:0] i_slot_generation,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_handle_index,
    output logic [15:0]      o_handle_generation,
    output logic             o_is_live,
    output logic [8:0]       o_live_count
);

    gha_pkg::t_req                    r_req;
    logic                             r_req_valid;
    logic                             accept;
    logic                             adv;
    logic                             take;
    logic                             res_valid;
    gha_pkg::t_result                 result;
    gha_pkg::t_gen_wr                 gen_wr;
    gha_pkg::t_stk_wr                 stk_wr;
    logic [gha_pkg::COUNT_BITS-1:0]   next_depth;
    logic [gha_pkg::COUNT_BITS-1:0]   stk_top;
    logic [gha_pkg::GEN_BITS-1:0]     gen_rd;
    gha_pkg::t_stk_entry              stk_rd;

    assign take    = res_valid && !i_stall;
    assign adv     = r_req_valid && (!res_valid || !i_stall);
    assign o_stall = r_req_valid && !adv;
    assign accept  = i_valid && !o_stall;
    assign stk_top = next_depth - gha_pkg::COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (accept) begin
            r_req_valid <= 1'b1;
        end else if (adv) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.kind            <= i_kind;
            r_req.slot_index      <= i_slot_index;
            r_req.slot_generation <= i_slot_generation;
        end
    end

    gha_ram #(
        .WIDTH (gha_pkg::GEN_BITS),
        .DEPTH (gha_pkg::SLOTS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_wr.en),
        .i_waddr (gen_wr.addr),
        .i_wdata (gen_wr.data),
        .i_re    (accept),
        .i_raddr (i_slot_index[gha_pkg::SLOT_BITS-1:0]),
        .o_rdata (gen_rd)
    );

    gha_ram #(
        .WIDTH (gha_pkg::STK_BITS),
        .DEPTH (gha_pkg::SLOTS)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_wr.en),
        .i_waddr (stk_wr.addr),
        .i_wdata (stk_wr.data),
        .i_re    (accept),
        .i_raddr (stk_top[gha_pkg::SLOT_BITS-1:0]),
        .o_rdata (stk_rd)
    );

    gha_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_take       (take),
        .i_req        (r_req),
        .i_gen_rd     (gen_rd),
        .i_stk_rd     (stk_rd),
        .o_gen_wr     (gen_wr),
        .o_stk_wr     (stk_wr),
        .o_next_depth (next_depth),
        .o_valid      (res_valid),
        .o_result     (result)
    );

    assign o_valid             = res_valid;
    assign o_status            = result.status;
    assign o_handle_index      = result.handle_index;
    assign o_handle_generation = result.handle_generation;
    assign o_is_live           = result.is_live;
    assign o_live_count        = result.live_count;

endmodule

`default_nettype wire
